FILE: rtl/core/iterative_mean_threshold_binarizer_assert.svh
// Assertion macros for the iterative mean threshold binarizer
`ifndef ITERATIVE_MEAN_THRESHOLD_BINARIZER_ASSERT_SVH
`define ITERATIVE_MEAN_THRESHOLD_BINARIZER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define IMTB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication with the consequent checked in the next cycle
`define IMTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/imtb_pkg.sv
// Package: shared types and constants of the binarizer
`timescale 1ns / 1ps
package imtb_pkg;
   localparam int unsigned MaxPixels = 65536;
   localparam int CntW = 17;
   localparam int SumW = 25;
   localparam logic [7:0] ResetThreshold = 8'd127;
   localparam logic [7:0] ResetMaxIter = 8'd32;
   localparam logic [7:0] WhiteValue = 8'd255;

   typedef enum logic [0:0] {
      CSR_INIT_THRESHOLD = 1'b0,
      CSR_MAX_ITERATIONS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CONVERGED = 2'd0,
      ST_CAP       = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic clear_acc;
      logic acc_step;
      logic div_start;
      logic load_init;
      logic update_t;
      logic clear_bin;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic t_same;
   } dp_status_type;
endpackage

FILE: rtl/core/iterative_mean_threshold_binarizer.sv
// Latency: binarize result in the cycle after acceptance; accumulate without last gives none.
// Accumulate with last: busy through search and clear; report strobe in its last cycle.
// Each iteration: histogram scan, drain, division and a decide step.
// Throughput: one transaction per cycle while not busy; receiver cannot stall.
// Synchronous active-high reset: threshold 127, no inversion, then busy while the
// histogram is cleared.
`timescale 1ns / 1ps
module iterative_mean_threshold_binarizer
   import imtb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [7:0] req_pixel,
   input  logic       req_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output logic       rsp_valid,
   output logic       rsp_is_report,
   output logic [7:0] rsp_out_pixel,
   output logic [7:0] rsp_threshold,
   output logic       rsp_inverted,
   output logic [1:0] rsp_status
);
   dp_cmd_type    cmd;
   dp_status_type stat;
   logic          accept, report, ctrl_busy;
   logic          bin_ff;
   logic [7:0]    bpix_ff, opix, thr;
   logic          inv;
   logic [1:0]    st;

   assign accept = start && !busy;

   imtb_controller u_ctrl (
      .clock(clock), .reset(reset), .search_go(accept && !req_cmd && req_last),
      .stat(stat), .cmd(cmd), .busy(ctrl_busy), .report(report));

   imtb_datapath u_dp (
      .clock(clock), .reset(reset), .acc_we(accept && !req_cmd), .acc_pixel(req_pixel),
      .bin_valid(bin_ff), .bin_pixel(bpix_ff), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .csr_sel(csr_index_type'(csr_index)), .cmd(cmd), .stat(stat),
      .out_pixel(opix), .threshold(thr), .inverted(inv), .status(st));

   always_ff @(posedge clock) begin
      if (reset) bin_ff <= 1'b0;
      else bin_ff <= accept && req_cmd;
      bpix_ff <= req_pixel;
   end

   assign busy = ctrl_busy;
   assign rsp_valid = bin_ff || report;
   assign rsp_is_report = report;
   assign rsp_out_pixel = opix;
   assign rsp_threshold = thr;
   assign rsp_inverted = inv;
   assign rsp_status = report ? st : ST_CONVERGED;
endmodule

FILE: rtl/core/imtb_divider.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module imtb_divider
   import imtb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SumW-1:0] dividend,
   input  logic [CntW-1:0] divisor,
   output logic            done,
   output logic [7:0]      quotient
);
   logic [SumW-1:0] q_ff, q_in;
   logic [CntW:0]   r_ff, r_in;
   logic [CntW-1:0] d_ff, d_in;
   logic [4:0]      n_ff, n_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [CntW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[CntW-1:0], q_ff[SumW-1]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         n_in = 5'(SumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[SumW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         n_in = n_ff - 5'd1;
         if (n_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; n_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; n_ff <= n_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = (d_ff == '0) ? 8'd0 : q_ff[7:0];
endmodule

FILE: rtl/core/imtb_datapath.sv
// Datapath: histogram memory, class sums, dividers and threshold registers
`timescale 1ns / 1ps
module imtb_datapath
   import imtb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          acc_we,
   input  logic [7:0]    acc_pixel,
   input  logic          bin_valid,
   input  logic [7:0]    bin_pixel,
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata,
   input  csr_index_type csr_sel,
   input  dp_cmd_type    cmd,
   output dp_status_type stat,
   output logic [7:0]    out_pixel,
   output logic [7:0]    threshold,
   output logic          inverted,
   output logic [1:0]    status
);
   logic [CntW-1:0] hist_mem [256];
   logic [CntW-1:0] rd_ff;
   logic [7:0]      rd_addr_ff, rd_addr_in;
   logic [7:0]      step_ff, step_in;
   logic            rd_vld_ff;
   logic            inc_vld_ff, wr_vld_ff;
   logic [7:0]      wr_addr_ff;
   logic [CntW-1:0] wr_data_ff, inc_val;
   logic [CntW-1:0] frame_ff;
   logic            ovf_ff;
   logic [7:0]      init_ff, maxit_ff, act_ff, t_ff, t_in;
   logic            pol_ff;
   logic [SumW-1:0] lo_sum_ff, hi_sum_ff;
   logic [CntW-1:0] lo_cnt_ff, hi_cnt_ff;
   logic            empty_ff, empty_in;
   logic [7:0]      lo_mean, hi_mean, nt;
   logic            lo_done, hi_done;
   logic [SumW-1:0] prod;
   logic            acc_ok;
   logic [8:0]      mean_sum;

   assign acc_ok = acc_we && (frame_ff != CntW'(MaxPixels));

   always_comb begin
      rd_addr_in = acc_pixel;
      step_in = step_ff;
      if (cmd.clear_acc) step_in = '0;
      if (cmd.acc_step || cmd.clear_bin) begin
         rd_addr_in = step_ff;
         step_in = step_ff + 8'd1;
      end
   end

   assign inc_val = ((wr_vld_ff && wr_addr_ff == rd_addr_ff) ? wr_data_ff : rd_ff) + CntW'(1);

   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[rd_addr_in];
      if (cmd.clear_bin) hist_mem[step_ff] <= '0;
      else if (inc_vld_ff) hist_mem[rd_addr_ff] <= inc_val;
      wr_addr_ff <= rd_addr_ff;
      wr_data_ff <= inc_val;
   end

   assign prod = SumW'(rd_ff) * SumW'(rd_addr_ff);

   assign mean_sum = {1'b0, lo_mean} + {1'b0, hi_mean};
   assign nt = mean_sum[8:1];

   always_comb begin
      t_in = t_ff;
      if (cmd.load_init) t_in = init_ff;
      else if (cmd.update_t) t_in = nt;
      empty_in = empty_ff;
      if (cmd.load_init) empty_in = 1'b0;
      else if (cmd.update_t && (lo_cnt_ff == '0 || hi_cnt_ff == '0)) empty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0; ovf_ff <= 1'b0; init_ff <= ResetThreshold;
         maxit_ff <= ResetMaxIter; act_ff <= ResetThreshold; pol_ff <= 1'b0;
         step_ff <= '0; rd_vld_ff <= 1'b0; empty_ff <= 1'b0; t_ff <= ResetThreshold;
         inc_vld_ff <= 1'b0; wr_vld_ff <= 1'b0;
      end else begin
         step_ff <= step_in; t_ff <= t_in; empty_ff <= empty_in;
         rd_vld_ff <= cmd.acc_step;
         inc_vld_ff <= acc_ok; wr_vld_ff <= inc_vld_ff;
         if (csr_we && csr_sel == CSR_INIT_THRESHOLD) init_ff <= csr_wdata;
         if (csr_we && csr_sel == CSR_MAX_ITERATIONS) maxit_ff <= csr_wdata;
         if (acc_ok) frame_ff <= frame_ff + CntW'(1);
         else if (acc_we) ovf_ff <= 1'b1;
         if (cmd.commit) begin
            act_ff <= t_ff;
            pol_ff <= lo_cnt_ff > hi_cnt_ff;
            frame_ff <= '0; ovf_ff <= 1'b0;
         end
      end
      rd_addr_ff <= rd_addr_in;
      if (cmd.clear_acc) begin
         lo_sum_ff <= '0; hi_sum_ff <= '0; lo_cnt_ff <= '0; hi_cnt_ff <= '0;
      end else if (rd_vld_ff) begin
         if (rd_addr_ff > t_ff) begin
            hi_sum_ff <= hi_sum_ff + prod; hi_cnt_ff <= hi_cnt_ff + rd_ff;
         end else begin
            lo_sum_ff <= lo_sum_ff + prod; lo_cnt_ff <= lo_cnt_ff + rd_ff;
         end
      end
   end

   imtb_divider u_lo_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(lo_sum_ff),
      .divisor(lo_cnt_ff), .done(lo_done), .quotient(lo_mean));
   imtb_divider u_hi_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(hi_sum_ff),
      .divisor(hi_cnt_ff), .done(hi_done), .quotient(hi_mean));

   logic [7:0] it_cnt_ff;
   logic       cap_hit;
   always_ff @(posedge clock) begin
      if (reset) it_cnt_ff <= '0;
      else if (cmd.load_init) it_cnt_ff <= '0;
      else if (cmd.update_t) it_cnt_ff <= it_cnt_ff + 8'd1;
   end
   assign cap_hit = (({1'b0, it_cnt_ff} + 9'd1) >=
                     {1'b0, ((maxit_ff == 8'd0) ? 8'd1 : maxit_ff)});

   assign stat.div_done = lo_done & hi_done;
   assign stat.t_same = (nt == t_ff) || cap_hit;

   logic conv_ff;
   always_ff @(posedge clock) begin
      if (reset) conv_ff <= 1'b0;
      else if (cmd.load_init) conv_ff <= 1'b0;
      else if (cmd.update_t && nt == t_ff) conv_ff <= 1'b1;
   end

   assign threshold = cmd.commit ? t_ff : act_ff;
   assign inverted  = cmd.commit ? (lo_cnt_ff > hi_cnt_ff) : pol_ff;
   assign out_pixel = bin_valid ? (((bin_pixel > act_ff) ^ pol_ff) ? WhiteValue : 8'd0) : 8'd0;
   always_comb begin
      if (ovf_ff) status = ST_OVERFLOW;
      else if (empty_ff) status = ST_EMPTY;
      else if (!conv_ff) status = ST_CAP;
      else status = ST_CONVERGED;
   end
endmodule

FILE: rtl/core/imtb_controller.sv
// Controller: sequences the threshold search and histogram clear
`timescale 1ns / 1ps
module imtb_controller
   import imtb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          search_go,
   input  dp_status_type stat,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          report
);
   `include "iterative_mean_threshold_binarizer_assert.svh"

   typedef enum logic [3:0] {
      S_WIPE, S_IDLE, S_PREP, S_SCAN, S_DRAIN, S_DIV, S_WAIT, S_DECIDE, S_CLEAR, S_FLUSH,
      S_REPORT
   } state_type;
   state_type state_ff, state_in;
   logic [8:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; cmd = '0;
      case (state_ff)
         S_WIPE: begin
            cmd.clear_bin = 1'b1; cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd255) begin
               cnt_in = '0; state_in = S_IDLE;
            end
         end
         S_IDLE: if (search_go) begin
            cmd.load_init = 1'b1; cmd.clear_acc = 1'b1; cnt_in = '0; state_in = S_PREP;
         end
         S_PREP: state_in = S_SCAN;
         S_SCAN: begin
            cmd.acc_step = 1'b1; cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd255) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_DIV;
         S_DIV: begin cmd.div_start = 1'b1; state_in = S_WAIT; end
         S_WAIT: if (stat.div_done) state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.update_t = 1'b1;
            if (stat.t_same) begin
               cmd.clear_acc = 1'b1; cnt_in = '0; state_in = S_CLEAR;
            end else begin
               cmd.clear_acc = 1'b1; cnt_in = '0; state_in = S_SCAN;
            end
         end
         S_CLEAR: begin
            cmd.acc_step = 1'b1; cmd.clear_bin = 1'b1; cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd255) state_in = S_FLUSH;
         end
         S_FLUSH: state_in = S_REPORT;
         S_REPORT: begin cmd.commit = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign report = (state_ff == S_REPORT);

   `IMTB_ASSERT_NEXT(a_go_busy, clock, reset, search_go && !busy, busy, "search did not start")
   `IMTB_ASSERT_IMP(a_rep_commit, clock, reset, report, cmd.commit, "report without commit")
   `IMTB_ASSERT_NEXT(a_rep_idle, clock, reset, report, !busy, "report not followed by idle")
endmodule
